// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers: clocked on clk, held off during reset.
`define AST_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define AST_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- design/ffpa_pkg.sv -----
`default_nettype none
package ffpa_pkg;
  localparam int MaxSegDef  = 16;
  localparam int AddrBitsDef = 16;
  localparam int IdBitsDef  = 8;
  localparam int WBits      = 16;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_XLATE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_MEM  = 3'd1;
  localparam logic [2:0] ST_TOO_BIG = 3'd2;
  localparam logic [2:0] ST_EXISTS  = 3'd3;
  localparam logic [2:0] ST_NOT_FND = 3'd4;
  localparam logic [2:0] ST_OFS_OOR = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  // Per-cell operations broadcast along the row
  typedef enum logic [2:0] {
    OP_HOLD, OP_SCAN, OP_INSERT, OP_REMOVE, OP_COMPACT, OP_CLEAR
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_GAP, S_EDIT, S_COMPACT, S_DONE
  } fsm_t;
endpackage
`default_nettype wire

// ----- design/ffpa_cell.sv -----
`default_nettype none
// One table slot. Cells form a row: each sees its left neighbour for
// insert shifts and compaction and its right neighbour for removal.
module ffpa_cell #(
  parameter int ID_BITS   = ffpa_pkg::IdBitsDef,
  parameter int ADDR_BITS = ffpa_pkg::AddrBitsDef
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire ffpa_pkg::cell_op_t       op,
  input  wire                           here,      // insert/remove point is this cell
  input  wire                           past,      // slot lies after the edit point
  input  wire [ID_BITS-1:0]             new_id,
  input  wire [ADDR_BITS-1:0]           new_base,
  input  wire [ffpa_pkg::WBits-1:0]     new_size,
  input  wire                           l_vld,
  input  wire [ID_BITS-1:0]             l_id,
  input  wire [ADDR_BITS-1:0]           l_base,
  input  wire [ffpa_pkg::WBits-1:0]     l_size,
  input  wire [ADDR_BITS-1:0]           l_end,     // left base+size for compaction
  input  wire                           r_vld,
  input  wire [ID_BITS-1:0]             r_id,
  input  wire [ADDR_BITS-1:0]           r_base,
  input  wire [ffpa_pkg::WBits-1:0]     r_size,
  input  wire                           first,
  output logic                          vld,
  output logic [ID_BITS-1:0]            id,
  output logic [ADDR_BITS-1:0]          base,
  output logic [ffpa_pkg::WBits-1:0]    size
);
  import ffpa_pkg::*;

  logic                  vld_r;
  logic [ID_BITS-1:0]    id_r;
  logic [ADDR_BITS-1:0]  base_r;
  logic [WBits-1:0]      size_r;

  // control: valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      unique case (op)
        OP_INSERT: if (here) vld_r <= 1'b1; else if (past) vld_r <= l_vld;
        OP_REMOVE: if (here || past) vld_r <= r_vld;
        OP_CLEAR:  vld_r <= 1'b0;
        default:   vld_r <= vld_r;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (op)
      OP_INSERT: begin
        if (here) begin
          id_r <= new_id; base_r <= new_base; size_r <= new_size;
        end else if (past) begin
          id_r <= l_id; base_r <= l_base; size_r <= l_size;
        end
      end
      OP_REMOVE: begin
        if (here || past) begin
          id_r <= r_id; base_r <= r_base; size_r <= r_size;
        end
      end
      OP_COMPACT: base_r <= first ? '0 : l_end;
      default: ;
    endcase
  end

  assign vld  = vld_r;
  assign id   = id_r;
  assign base = base_r;
  assign size = size_r;
endmodule
`default_nettype wire

// ----- design/first_fit_partition_allocator_core.sv -----
`default_nettype none
// First-fit segment allocator with compaction.
// in_ channel: one request word (cmd, proc_id, size, offset) per handshake.
// out_ channel: one result word (status, address, free_words) per request.
// cfg_: memory_size register, write only while the block is idle.
// Segments live in a row of MAX_SEGMENTS cells sorted by base. A request
// goes through the id search, the gap scan (a start that passes its checks),
// a compaction when needed, the table edit (accepted start or found stop)
// and a final state that registers the result. The next request is taken
// in the idle state that follows. The scan cursor visits one slot per cycle.
// Compaction ripples one base a cycle down the row, each cell taking the
// end of its left neighbour.
// Reset empties the table, clears the allocated count and memory_size.
// The result waits in an output register while out_tready is low; the next
// request may be taken meanwhile, and its result holds in the final stage
// until the output register is free.
module first_fit_partition_allocator_core
  import ffpa_pkg::*;
#(
  parameter int MAX_SEGMENTS = MaxSegDef,
  parameter int ADDR_BITS    = AddrBitsDef,
  parameter int ID_BITS      = IdBitsDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [15:0] cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // cmd[1:0], proc_id[9:2], size_request[25:10], offset[41:26]
  input  wire  [47:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // status[2:0], address[18:3], free_words[34:19]
  output logic [39:0] out_tdata
);
  import ffpa_pkg::*;
  `include "assert_macros.svh"

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int XW = ADDR_BITS + 2;  // wide cursor

  fsm_t state_r, state_nxt;
  logic [WBits-1:0] mem_size_r;
  logic [WBits+8:0] alloc_r, alloc_nxt;   // 9 spare bits; a start never takes it past memory_size
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    idx_r;
  logic [1:0]       cmd_r;
  logic [ID_BITS-1:0] pid_r;
  logic [WBits-1:0] sz_r, ofs_r;
  logic             found_r;
  logic [IW-1:0]    fidx_r;
  logic [IW-1:0]    pos_r;
  logic [XW-1:0]    cur_r;
  logic             gap_r;
  logic [2:0]       st_r;
  logic [WBits-1:0] addr_r;
  logic [39:0]      odata_r;
  logic             ovld_r;

  cell_op_t op;
  logic [MAX_SEGMENTS-1:0]    c_vld;
  logic [ID_BITS-1:0]         c_id   [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0]       c_base [MAX_SEGMENTS];
  logic [WBits-1:0]           c_size [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0]       new_base;

  // Row of cells
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == MAX_SEGMENTS - 1) ? g : g + 1;
    logic [ADDR_BITS-1:0] lend;
    assign lend = c_base[L] + ADDR_BITS'(c_size[L]);
    ffpa_cell #(.ID_BITS(ID_BITS), .ADDR_BITS(ADDR_BITS)) u_cell (
      .clk, .rst_n, .op,
      .here (pos_r == IW'(g)),
      .past (IW'(g) > pos_r),
      .new_id(pid_r), .new_base(new_base), .new_size(sz_r),
      .l_vld(g == 0 ? 1'b0 : c_vld[L]), .l_id(c_id[L]), .l_base(c_base[L]),
      .l_size(c_size[L]), .l_end(lend),
      .r_vld(g == MAX_SEGMENTS - 1 ? 1'b0 : c_vld[R]), .r_id(c_id[R]),
      .r_base(c_base[R]), .r_size(c_size[R]),
      .first(g == 0),
      .vld(c_vld[g]), .id(c_id[g]), .base(c_base[g]), .size(c_size[g])
    );
  end

  // current slot under the cursor
  logic [IW-1:0]       ci;
  logic [ID_BITS-1:0]  s_id;
  logic [ADDR_BITS-1:0] s_base;
  logic [WBits-1:0]    s_size, fsize;
  logic [ADDR_BITS-1:0] fbase;
  logic                at_end;
  logic [WBits-1:0]    free_now;
  logic [XW-1:0]       gapw;
  logic                fits;
  logic [XW-1:0]       tail;

  assign ci     = idx_r[IW-1:0];
  assign s_id   = c_id[ci];
  assign s_base = c_base[ci];
  assign s_size = c_size[ci];
  assign fsize  = c_size[fidx_r];
  assign fbase  = c_base[fidx_r];
  assign at_end = (idx_r >= cnt_r);
  assign free_now = ({9'd0, mem_size_r} > alloc_r) ?
                    WBits'({9'd0, mem_size_r} - alloc_r) : '0;
  assign gapw = XW'(s_base) - cur_r;
  assign fits = (XW'(s_base) >= cur_r) && (gapw >= XW'(sz_r));
  assign tail = XW'(mem_size_r) - cur_r;
  assign new_base = ADDR_BITS'(cur_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_tvalid && in_tready) state_nxt = S_SCAN;
      S_SCAN: begin
        if (at_end || found_r) begin
          if (cmd_r == CMD_START) state_nxt = S_GAP;
          else if (cmd_r == CMD_STOP && found_r) state_nxt = S_EDIT;
          else state_nxt = S_DONE;
        end
      end
      S_GAP:     if (gap_r || at_end) state_nxt = S_EDIT;
      S_COMPACT: if (idx_r >= CW'(MAX_SEGMENTS - 1)) state_nxt = S_EDIT;
      S_EDIT:    state_nxt = S_DONE;
      S_DONE:    if (!ovld_r || out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
    if (state_r == S_SCAN && (at_end || found_r) && cmd_r == CMD_START &&
        (mem_size_r == '0 || sz_r > free_now || found_r || cnt_r == CW'(MAX_SEGMENTS)))
      state_nxt = S_DONE;
    if (state_r == S_GAP && at_end && !gap_r &&
        ((XW'(mem_size_r) < cur_r) || (tail < XW'(sz_r))))
      state_nxt = S_COMPACT;
  end

  // cell operation
  always_comb begin
    op = OP_HOLD;
    unique case (state_r)
      S_COMPACT: op = OP_COMPACT;
      S_EDIT:    op = (cmd_r == CMD_START) ? OP_INSERT : OP_REMOVE;
      default:   op = OP_HOLD;
    endcase
    if (!rst_n) op = OP_CLEAR;
  end

  assign in_tready = (state_r == S_IDLE);

  // control and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; mem_size_r <= '0; alloc_r <= '0; cnt_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
      if (cfg_we) mem_size_r <= cfg_wdata;
      if (state_r == S_EDIT) begin
        if (cmd_r == CMD_START) cnt_r <= cnt_r + 1'b1;
        else cnt_r <= cnt_r - 1'b1;
      end
      if (state_r == S_DONE && (!ovld_r || out_tready)) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
    end
  end

  always_comb begin
    alloc_nxt = alloc_r;
    if (state_r == S_EDIT) begin
      if (cmd_r == CMD_START) alloc_nxt = alloc_r + (WBits+9)'(sz_r);
      else alloc_nxt = alloc_r - (WBits+9)'(fsize);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        cmd_r <= in_tdata[1:0];
        pid_r <= ID_BITS'(in_tdata[9:2]);
        sz_r  <= in_tdata[25:10];
        ofs_r <= in_tdata[41:26];
        idx_r <= '0; found_r <= 1'b0; fidx_r <= '0;
        st_r <= ST_OK; addr_r <= '0;
      end
      S_SCAN: begin
        if (!at_end && !found_r && c_vld[ci] && s_id == pid_r) begin
          found_r <= 1'b1; fidx_r <= ci;
        end else if (!at_end && !found_r) idx_r <= idx_r + 1'b1;
        if (at_end || found_r) begin
          idx_r <= '0; cur_r <= '0; gap_r <= 1'b0;
          if (cmd_r == CMD_START) begin
            if (mem_size_r == '0) st_r <= ST_NO_MEM;
            else if (sz_r > free_now) st_r <= ST_TOO_BIG;
            else if (found_r) st_r <= ST_EXISTS;
            else if (cnt_r == CW'(MAX_SEGMENTS)) st_r <= ST_FULL;
          end else if (cmd_r == CMD_STOP) begin
            if (!found_r) st_r <= ST_NOT_FND;
            else pos_r <= fidx_r;
          end else if (cmd_r == CMD_XLATE) begin
            if (!found_r) st_r <= ST_NOT_FND;
            else if (ofs_r >= fsize) st_r <= ST_OFS_OOR;
            else addr_r <= WBits'(fbase + ADDR_BITS'(ofs_r));
          end
        end
      end
      S_GAP: begin
        if (!gap_r && !at_end) begin
          if (fits) begin
            gap_r <= 1'b1; pos_r <= ci;
          end else begin
            cur_r <= XW'(s_base) + XW'(s_size);
            idx_r <= idx_r + 1'b1;
          end
        end
        if (!gap_r && at_end) begin
          pos_r <= IW'(cnt_r);
          idx_r <= '0;
        end
      end
      S_COMPACT: begin
        idx_r <= idx_r + 1'b1;
        // the compacted segments end at the allocated word count
        cur_r <= XW'(alloc_r);
      end
      S_EDIT: addr_r <= WBits'(cur_r);
      default: ;
    endcase
    if (state_r == S_DONE && (!ovld_r || out_tready))
      odata_r <= {5'd0, free_now, (st_r == ST_OK) ? addr_r : 16'd0, st_r};
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  `AST_IMP(a_cnt_max, 1'b1, cnt_r <= CW'(MAX_SEGMENTS))
  `AST_IMP(a_no_accept_busy, state_r != S_IDLE, !in_tready)
  `AST_NXT(a_edit_done, state_r == S_EDIT, state_r == S_DONE)
endmodule
`default_nettype wire

// ----- tb/first_fit_partition_allocator_core_tb.sv -----
`timescale 1ns / 100ps
module first_fit_partition_allocator_core_tb;
  import ffpa_pkg::*;

  localparam int NSEG = 16;

  // last field in the lowest bits
  typedef struct packed {
    logic [15:0] ofs;
    logic [15:0] size;
    logic [7:0]  pid;
    logic [1:0]  cmd;
  } req_t;

  typedef struct packed {
    logic [15:0] free_words;
    logic [15:0] address;
    logic [2:0]  status;
  } rsp_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;

  first_fit_partition_allocator_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state: own copy of the segment table
  logic [7:0]  seg_id [NSEG];
  logic [16:0] seg_base [NSEG];
  logic [16:0] seg_size [NSEG];
  int          seg_cnt;
  logic [16:0] alloc_words;
  logic [15:0] mem_words;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   n_checked = 0;
  int   n_compact = 0;
  bit   quiet = 0;
  bit   hold_sender = 0;
  bit   in_taken = 0;

  function automatic logic [15:0] words_free();
    return (mem_words > alloc_words) ? 16'(mem_words - alloc_words) : 16'd0;
  endfunction

  function automatic int lookup_id(logic [7:0] id);
    for (int i = 0; i < seg_cnt; i++) if (seg_id[i] == id) return i;
    return -1;
  endfunction

  task automatic queue_req(req_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic put_seg(int pos, logic [7:0] id, logic [16:0] b, logic [16:0] s);
    for (int i = seg_cnt; i > pos; i--) begin
      seg_id[i] = seg_id[i-1]; seg_base[i] = seg_base[i-1]; seg_size[i] = seg_size[i-1];
    end
    seg_id[pos] = id; seg_base[pos] = {1'b0, b[15:0]}; seg_size[pos] = s;
    seg_cnt++;
    alloc_words += s;
  endtask

  // Work out the result of one request and update the table
  task automatic allocate_predict(req_t r);
    rsp_t o;
    logic [16:0] cur;
    int k;
    bit placed;
    o = '0;
    k = lookup_id(r.pid);
    case (r.cmd)
      CMD_START: begin
        if (mem_words == 0) o.status = ST_NO_MEM;
        else if (r.size > words_free()) o.status = ST_TOO_BIG;
        else if (k >= 0) o.status = ST_EXISTS;
        else if (seg_cnt >= NSEG) o.status = ST_FULL;
        else begin
          cur = 0; placed = 0;
          for (int i = 0; i < seg_cnt && !placed; i++) begin
            if (seg_base[i] >= cur && seg_base[i] - cur >= r.size) begin
              put_seg(i, r.pid, cur, r.size);
              o.address = cur[15:0];
              placed = 1;
            end else cur = seg_base[i] + seg_size[i];
          end
          if (!placed) begin
            if (mem_words < cur || mem_words - cur < r.size) begin
              cur = 0;
              for (int i = 0; i < seg_cnt; i++) begin
                seg_base[i] = {1'b0, cur[15:0]};
                cur += seg_size[i];
              end
              n_compact++;
            end
            put_seg(seg_cnt, r.pid, cur, r.size);
            o.address = cur[15:0];
          end
        end
      end
      CMD_STOP: begin
        if (k < 0) o.status = ST_NOT_FND;
        else begin
          alloc_words -= seg_size[k];
          for (int i = k; i + 1 < seg_cnt; i++) begin
            seg_id[i] = seg_id[i+1]; seg_base[i] = seg_base[i+1];
            seg_size[i] = seg_size[i+1];
          end
          seg_cnt--;
        end
      end
      CMD_XLATE: begin
        if (k < 0) o.status = ST_NOT_FND;
        else if ({1'b0, r.ofs} >= seg_size[k]) o.status = ST_OFS_OOR;
        else o.address = 16'(seg_base[k] + r.ofs);
      end
      default: ;
    endcase
    o.free_words = words_free();
    expected_rsps = {expected_rsps, o};
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %0s: got %0h want %0h (result %0d)", what, got, want, n_checked);
  endtask

  // Input side: a word is taken at a rising edge with valid and ready high
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      allocate_predict(req_t'(in_tdata[41:0]));
      in_taken = 1;
    end
  end

  // Driver: present the next pending word at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 0;
        if (pending_reqs.size() > 0 && !hold_sender && (quiet || $urandom_range(99) >= 29)) begin
          in_tdata <= {6'b0, pending_reqs.pop_front()};
          in_tvalid <= 1;
        end else in_tvalid <= 0;
      end
      out_tready <= quiet || ($urandom_range(99) >= 29);
    end
  end

  // Monitor: compare each delivered result word with the oldest expectation
  always @(posedge clk) begin
    rsp_t g, e;
    if (rst_n && out_tvalid && out_tready) begin
      g = rsp_t'(out_tdata[34:0]);
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[15:0], 16'd0);
      end else begin
        e = expected_rsps.pop_front();
        if (g.status !== e.status) report_mismatch("status", 16'(g.status), 16'(e.status));
        if (g.address !== e.address) report_mismatch("address", g.address, e.address);
        if (g.free_words !== e.free_words)
          report_mismatch("free_words", g.free_words, e.free_words);
      end
      n_checked++;
    end
  end

  function automatic req_t mk(logic [1:0] c, logic [7:0] p, logic [15:0] s, logic [15:0] o);
    req_t r;
    r.cmd = c; r.pid = p; r.size = s; r.ofs = o;
    return r;
  endfunction

  // Wait for all words to be consumed and all results delivered
  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_rsps.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_memory(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    mem_words = v;
  endtask

  // Mostly well-formed traffic on a small id pool so that hits are common
  task automatic random_phase(int n, int size_max);
    logic [7:0] id;
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(19));
      case ($urandom_range(9))
        0, 1, 2, 3: queue_req(mk(CMD_START, id,
                      16'($urandom_range(size_max)), 16'($urandom)));
        4, 5: queue_req(mk(CMD_STOP, id, 16'($urandom), 16'($urandom)));
        6, 7: queue_req(mk(CMD_XLATE, id, 16'($urandom),
                16'($urandom_range(size_max))));
        8: queue_req(mk(CMD_XLATE, id, 16'($urandom), 16'($urandom)));
        default: queue_req(mk(2'($urandom_range(3)), 8'($urandom),
                   16'($urandom), 16'($urandom)));
      endcase
    end
  endtask

  initial begin
    seg_cnt = 0; alloc_words = 0; mem_words = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: no memory, then start/stop/translate corners
    queue_req(mk(CMD_START, 8'd1, 16'd1, 16'd0));
    queue_req(mk(CMD_XLATE, 8'd1, 16'd0, 16'd0));
    drain();
    set_memory(16'd100);
    queue_req(mk(CMD_START, 8'd1, 16'd30, 16'd0));
    queue_req(mk(CMD_START, 8'd2, 16'd30, 16'd0));
    queue_req(mk(CMD_START, 8'd3, 16'd30, 16'd0));
    queue_req(mk(CMD_START, 8'd1, 16'd1, 16'd0));
    queue_req(mk(CMD_START, 8'd4, 16'd11, 16'd0));
    queue_req(mk(CMD_STOP, 8'd2, 16'd0, 16'd0));
    queue_req(mk(CMD_START, 8'd5, 16'd0, 16'd0));
    queue_req(mk(CMD_START, 8'd6, 16'd35, 16'd0));
    queue_req(mk(CMD_XLATE, 8'd3, 16'd0, 16'd29));
    queue_req(mk(CMD_XLATE, 8'd3, 16'd0, 16'd30));
    queue_req(mk(CMD_XLATE, 8'd3, 16'd0, 16'hFFFF));
    queue_req(mk(CMD_XLATE, 8'd99, 16'd0, 16'd0));
    queue_req(mk(CMD_STOP, 8'd99, 16'd0, 16'd0));
    queue_req(mk(2'd3, 8'hFF, 16'hFFFF, 16'hFFFF));
    queue_req(mk(CMD_STOP, 8'd3, 16'd0, 16'd0));
    queue_req(mk(CMD_START, 8'd7, 16'd65, 16'd0));
    queue_req(mk(CMD_XLATE, 8'd7, 16'd0, 16'd64));
    drain();
    // Shrink below allocation; only zero-size starts can proceed
    set_memory(16'd10);
    queue_req(mk(CMD_START, 8'd8, 16'd1, 16'd0));
    queue_req(mk(CMD_START, 8'd8, 16'd0, 16'd0));
    drain();
    // Table full on the largest memory
    set_memory(16'hFFFF);
    for (int i = 0; i < NSEG + 1; i++)
      queue_req(mk(CMD_START, 8'(200 + i), 16'h0F00, 16'd0));
    queue_req(mk(CMD_START, 8'hFF, 16'hFFFF, 16'd0));
    drain();
    for (int i = 0; i < NSEG + 3; i++)
      queue_req(mk(CMD_STOP, 8'(i < 4 ? i : 197 + i), 16'd0, 16'd0));
    drain();

    // Random phases over several memory sizes
    set_memory(16'd200);  random_phase(180, 40);  drain();
    set_memory(16'd1);    random_phase(60, 2);    drain();
    set_memory(16'd5000); random_phase(100, 900);
    // wait until everything has come back, then hold the sender over a second wait
    while (expected_rsps.size() > 0 || in_tvalid || pending_reqs.size() > 0) @(posedge clk);
    hold_sender = 1;
    while (expected_rsps.size() > 0) @(posedge clk);
    hold_sender = 0;
    quiet = 1; random_phase(120, 900); drain(); quiet = 0;
    set_memory(16'hFFFF); random_phase(160, 16'hFFFF); drain();
    set_memory(16'd0);    random_phase(40, 50);   drain();

    $display("checked %0d result words, %0d compactions, memory sizes 0 to 65535",
             n_checked, n_compact);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
